// ===== rtl/ptsp_pkg.sv =====
`default_nettype none
package ptsp_pkg;

	localparam logic [7:0] TS_SYNC        = 8'h47;
	localparam logic [7:0] TS_PAYLOAD     = 8'd184;
	localparam logic [7:0] PCR_PAYLOAD    = 8'd176;
	localparam logic [7:0] STREAM_ID_VID  = 8'hE0;
	localparam logic [7:0] PCR_FLAG_BYTE  = 8'h10;
	localparam logic [7:0] STUFF_BYTE     = 8'hFF;
	localparam logic [7:0] PES_FLAGS_BYTE = 8'h84;
	localparam logic [5:0] PCR_RESERVED   = 6'h3F;
	localparam logic [4:0] HSIZE_PTS      = 5'd14;
	localparam logic [4:0] HSIZE_DTS      = 5'd19;
	localparam int         PES_MAX        = 19;
	localparam logic [0:0] REG_PID        = 1'b0;
	localparam logic [0:0] REG_STREAM_ID  = 1'b1;

	typedef struct packed {
		logic load;
		logic hdr_byte;
		logic data_byte;
		logic flush;
	} ptsp_cmd_t;

	typedef struct packed {
		logic drop;
		logic need_head;
		logic hdr_last;
		logic byte_ok;
		logic flush_ok;
	} ptsp_status_t;

endpackage
`default_nettype wire

// ===== rtl/pes_to_ts_packetizer_unit.sv =====
// Sequence: an item is accepted, then header bytes go out one by one when a packet head
// is due, then the data byte, then a flush step pushes out any held word.
// Throughput: one item at a time; the byte sequencer emits one stream byte per cycle unless
// the output is full. Words leave through a one-word hold stage and an output register.
// Reset (arst_n low, async): pid 256, stream id 0xE0; counters, byte buffer, valids cleared.
`default_nettype none
module pes_to_ts_packetizer_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [0:0]  cfg_index,
	input  wire  [12:0] cfg_data,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [95:0] s_axis_tdata,  // data_byte, unit_length, pts, dts, zero fill
	input  wire  [2:0]  s_axis_tuser,  // first_of_unit, has_dts, insert_pcr
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,  // ts_word
	output logic [0:0]  m_axis_tuser,  // packet_end
	output logic        m_axis_tlast
);
	import ptsp_pkg::*;

	ptsp_cmd_t    cmd;
	ptsp_status_t status;

	assign cfg_ready = 1'b1;

	ptsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ptsp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_data_byte   (s_axis_tdata[7:0]),
		.in_first       (s_axis_tuser[0]),
		.in_unit_length (s_axis_tdata[23:8]),
		.in_pts         (s_axis_tdata[56:24]),
		.in_dts         (s_axis_tdata[89:57]),
		.in_has_dts     (s_axis_tuser[1]),
		.in_insert_pcr  (s_axis_tuser[2]),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_word       (m_axis_tdata),
		.out_packet_end (m_axis_tuser[0]),
		.out_last       (m_axis_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/ptsp_ctrl.sv =====
`default_nettype none
module ptsp_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  ptsp_pkg::ptsp_status_t status,
	output ptsp_pkg::ptsp_cmd_t    cmd
);
	import ptsp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_HEAD  = 4'b0010,
		ST_DATA  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.drop) state_d = ST_IDLE;
					else if (status.need_head) state_d = ST_HEAD;
					else state_d = ST_DATA;
				end
			end
			ST_HEAD: begin
				cmd.hdr_byte = status.byte_ok;
				if (status.byte_ok && status.hdr_last) state_d = ST_DATA;
			end
			ST_DATA: begin
				cmd.data_byte = status.byte_ok;
				if (status.byte_ok) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (status.flush_ok) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ptsp_dp.sv =====
`default_nettype none
module ptsp_dp (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_valid,
	input  wire  [0:0]             cfg_index,
	input  wire  [12:0]            cfg_data,
	input  wire  [7:0]             in_data_byte,
	input  wire                    in_first,
	input  wire  [15:0]            in_unit_length,
	input  wire  [32:0]            in_pts,
	input  wire  [32:0]            in_dts,
	input  wire                    in_has_dts,
	input  wire                    in_insert_pcr,
	input  ptsp_pkg::ptsp_cmd_t    cmd,
	output ptsp_pkg::ptsp_status_t status,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [31:0]            out_word,
	output logic                   out_packet_end,
	output logic                   out_last
);
	import ptsp_pkg::*;

	logic [12:0] pid_q;
	logic [7:0]  sid_q;
	logic [3:0]  cc_q;
	logic [15:0] ubl_q;
	logic [7:0]  ppl_q;
	logic [23:0] buf_q;
	logic [1:0]  fill_q;
	logic [7:0]  k_q, hdr_len_q, af_q;
	logic        start_q, pcr_q, has_dts_q;
	logic [7:0]  data_q;
	logic [32:0] pts_q, dts_q;
	logic [15:0] plen_q;
	logic        pv_q, pe_q;
	logic [31:0] pw_q;
	logic        ov_q, oe_q, ol_q;
	logic [31:0] ow_q;

	logic [15:0] len1;
	logic [4:0]  hsize_in;
	logic [16:0] total;
	logic [7:0]  cap, pl_first, pl_cont, af_first, af_cont;
	logic        out_free, emit, word_done, byte_end;
	logic [7:0]  cur_byte, j, m8;
	logic [39:0] pts_f, dts_f;
	logic [47:0] pcr_f, pcr_sh;
	logic [7:0]  pes_b [PES_MAX];
	logic [4:0]  m_idx;
	logic [7:0]  ppl_dec;

	assign len1     = (in_unit_length == 16'd0) ? 16'd1 : in_unit_length;
	assign hsize_in = in_has_dts ? HSIZE_DTS : HSIZE_PTS;
	assign total    = {1'b0, len1} + {12'd0, hsize_in};
	assign cap      = in_insert_pcr ? PCR_PAYLOAD : TS_PAYLOAD;
	assign pl_first = (total < {9'd0, cap}) ? total[7:0] : cap;
	assign af_first = TS_PAYLOAD - pl_first;
	assign pl_cont  = (ubl_q < {8'd0, TS_PAYLOAD}) ? ubl_q[7:0] : TS_PAYLOAD;
	assign af_cont  = TS_PAYLOAD - pl_cont;

	assign status.drop      = !in_first && (ubl_q == 16'd0);
	assign status.need_head = in_first || (ppl_q == 8'd0);
	assign status.hdr_last  = (k_q == hdr_len_q - 8'd1);

	assign out_free        = !ov_q || out_ready;
	assign status.byte_ok  = (fill_q != 2'd3) || !pv_q || out_free;
	assign status.flush_ok = !pv_q || out_free;

	assign pts_f = {(has_dts_q ? 4'd3 : 4'd2), pts_q[32:30], 1'b1, pts_q[29:15], 1'b1,
		pts_q[14:0], 1'b1};
	assign dts_f = {4'd1, dts_q[32:30], 1'b1, dts_q[29:15], 1'b1, dts_q[14:0], 1'b1};
	assign pcr_f = {(has_dts_q ? dts_q : pts_q), PCR_RESERVED, 9'd0};

	always_comb begin
		pes_b[0]  = 8'h00;
		pes_b[1]  = 8'h00;
		pes_b[2]  = 8'h01;
		pes_b[3]  = sid_q;
		pes_b[4]  = (sid_q == STREAM_ID_VID) ? 8'h00 : plen_q[15:8];
		pes_b[5]  = (sid_q == STREAM_ID_VID) ? 8'h00 : plen_q[7:0];
		pes_b[6]  = PES_FLAGS_BYTE;
		pes_b[7]  = has_dts_q ? 8'hC0 : 8'h80;
		pes_b[8]  = has_dts_q ? 8'd10 : 8'd5;
		pes_b[9]  = pts_f[39:32];
		pes_b[10] = pts_f[31:24];
		pes_b[11] = pts_f[23:16];
		pes_b[12] = pts_f[15:8];
		pes_b[13] = pts_f[7:0];
		pes_b[14] = dts_f[39:32];
		pes_b[15] = dts_f[31:24];
		pes_b[16] = dts_f[23:16];
		pes_b[17] = dts_f[15:8];
		pes_b[18] = dts_f[7:0];
	end

	assign j      = k_q - 8'd4;
	assign m8     = j - af_q;
	assign m_idx  = m8[4:0];
	assign pcr_sh = pcr_f << {j[2:0] - 3'd2, 3'b000};

	always_comb begin
		cur_byte = STUFF_BYTE;
		if (k_q < 8'd4) begin
			case (k_q[1:0])
				2'd0: cur_byte = TS_SYNC;
				2'd1: cur_byte = {1'b0, start_q, 1'b0, pid_q[12:8]};
				2'd2: cur_byte = pid_q[7:0];
				default: cur_byte = {2'b00, (af_q != 8'd0), 1'b1, cc_q};
			endcase
		end else if (j < af_q) begin
			if (af_q == 8'd1) cur_byte = 8'h00;
			else if (j == 8'd0) cur_byte = af_q - 8'd1;
			else if (j == 8'd1) cur_byte = pcr_q ? PCR_FLAG_BYTE : 8'h00;
			else if (pcr_q && j < 8'd8) cur_byte = pcr_sh[47:40];
			else cur_byte = STUFF_BYTE;
		end else if (m8 < 8'(PES_MAX)) begin
			cur_byte = pes_b[m_idx];
		end
		if (cmd.data_byte) cur_byte = data_q;
	end

	assign ppl_dec   = ppl_q - 8'd1;
	assign emit      = cmd.hdr_byte || cmd.data_byte;
	assign word_done = emit && (fill_q == 2'd3);
	assign byte_end  = cmd.data_byte && (ppl_dec == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_q   <= 13'd256;
			sid_q   <= STREAM_ID_VID;
			cc_q    <= '0;
			ubl_q   <= '0;
			ppl_q   <= '0;
			buf_q   <= '0;
			fill_q  <= '0;
			k_q     <= '0;
			pv_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_PID:       pid_q <= cfg_data;
					REG_STREAM_ID: sid_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				k_q <= '0;
				if (in_first) begin
					ubl_q  <= len1;
					ppl_q  <= pl_first - {3'd0, hsize_in};
					buf_q  <= '0;
					fill_q <= '0;
				end else if (ppl_q == 8'd0) begin
					ppl_q <= pl_cont;
				end
			end
			if (cmd.hdr_byte) begin
				k_q <= k_q + 8'd1;
				if (k_q == 8'd3) cc_q <= cc_q + 4'd1;
			end
			if (cmd.data_byte) begin
				ppl_q <= ppl_dec;
				ubl_q <= ubl_q - 16'd1;
			end
			if (emit) begin
				if (fill_q == 2'd3) begin
					buf_q  <= '0;
					fill_q <= '0;
				end else begin
					buf_q  <= {buf_q[15:0], cur_byte};
					fill_q <= fill_q + 2'd1;
				end
			end
			if (word_done) begin
				pv_q <= 1'b1;
				if (pv_q) ov_q <= 1'b1;
				else if (out_ready) ov_q <= 1'b0;
			end else if (cmd.flush && pv_q && out_free) begin
				pv_q <= 1'b0;
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q    <= in_data_byte;
			pts_q     <= in_pts;
			dts_q     <= in_dts;
			has_dts_q <= in_has_dts;
			plen_q    <= total[15:0] - 16'd6;
			start_q   <= in_first;
			pcr_q     <= in_first && in_insert_pcr;
			af_q      <= in_first ? af_first : af_cont;
			hdr_len_q <= in_first ? (8'd4 + af_first + {3'd0, hsize_in}) : (8'd4 + af_cont);
		end
		if (word_done) begin
			pw_q <= {buf_q, cur_byte};
			pe_q <= byte_end;
			if (pv_q) begin
				ow_q <= pw_q;
				oe_q <= pe_q;
				ol_q <= 1'b0;
			end
		end else if (cmd.flush && pv_q && out_free) begin
			ow_q <= pw_q;
			oe_q <= pe_q;
			ol_q <= 1'b1;
		end
	end

	assign out_valid      = ov_q;
	assign out_word       = ow_q;
	assign out_packet_end = oe_q;
	assign out_last       = ol_q;

endmodule
`default_nettype wire
